// ----- design/motor_move_mode_controller_assert.svh -----
// Assertion helpers shared by the controller RTL.
// Each check is disabled while reset is asserted.
`ifndef MOTOR_MOVE_MODE_CONTROLLER_ASSERT_SVH
`define MOTOR_MOVE_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define MMMC_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define MMMC_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/mmmc_pkg.sv -----
`timescale 1ns / 1ps

package mmmc_pkg;

    // default width of the integrated shaft angles
    localparam int ANGLE_BITS_DEF = 48;

    // field widths
    localparam int TICK_W      = 20;
    localparam int POWER_W     = 12;
    localparam int DEG_W       = 31;
    localparam int ROT_W       = 22;
    localparam int SECS_W      = 32;
    localparam int SPEED_W     = 23;
    localparam int MAXSPD_W    = 22;
    localparam int ANGLE_OUT_W = 48;
    localparam int MODE_W      = 3;
    localparam int GOAL_W      = 32;
    localparam int STEP_W      = 23;
    localparam int CFG_IDX_W   = 1;

    localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST = 22'd990000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 1'b1;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_DEG   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TIMED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd4;

    // one tick as it travels down the pipeline
    typedef struct packed {
        logic [TICK_W-1:0]         tick;
        logic signed [POWER_W-1:0] power;
        logic signed [DEG_W-1:0]   deg;
        logic                      deg_act;
        logic signed [ROT_W-1:0]   rot;
        logic signed [GOAL_W-1:0]  rot360;
        logic [SECS_W-1:0]         secs;
        logic                      pzero;
        logic                      cneg;
        logic [MAXSPD_W-1:0]       mag;
    } mmmc_item_t;

endpackage

// ----- design/mmmc_step_calc.sv -----
`timescale 1ns / 1ps

// Angle step for one tick: round(speed_mag * tick / 1e6), ties away from zero.
// Four register stages; the divide by 1e6 is a shift by 6, a reciprocal
// multiply for 15625 on the upper bits, and a small remainder correction.
module mmmc_step_calc import mmmc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [MAXSPD_W-1:0] speed_mag,
    input  logic [TICK_W-1:0]   tick,
    output logic [STEP_W-1:0]   step
);

    localparam int PROD_W      = MAXSPD_W + TICK_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int PRE_SHIFT   = 6;
    localparam int X_W         = SUM_W - PRE_SHIFT;
    localparam int LO_BITS     = 14;
    localparam int XH_W        = X_W - LO_BITS;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int QM_W        = XH_W + RECIP_W;
    localparam int Q_W         = QM_W - RECIP_SHIFT;
    localparam int DIV_W       = 14;
    localparam int RQ_W        = Q_W + DIV_W;
    localparam int R_W         = 16;

    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(500000);
    // floor(2^38 / 15625)
    localparam logic [RECIP_W-1:0] RECIP      = 25'd17592186;
    localparam logic [DIV_W-1:0]   DIVISOR    = 14'd15625;
    localparam logic [R_W-1:0]     DIV_ONE    = R_W'(DIVISOR);
    localparam logic [R_W-1:0]     DIV_TWO    = R_W'(2 * 15625);

    logic [PROD_W-1:0] pstep_reg;
    logic [X_W-1:0]    x_reg;
    logic [Q_W-1:0]    q_reg;
    logic [R_W-1:0]    r_reg;
    logic [Q_W-1:0]    q2_reg;
    logic [STEP_W-1:0] step_reg;

    logic [SUM_W-1:0]  sum;
    logic [X_W-1:0]    x_next;
    logic [QM_W-1:0]   qm;
    logic [Q_W-1:0]    q_next;
    logic [RQ_W-1:0]   rq;
    logic [X_W-1:0]    rem;
    logic [Q_W-1:0]    step_next;

    // estimate the quotient from the upper bits (never above the true value)
    assign sum    = SUM_W'(pstep_reg) + ROUND_HALF;
    assign x_next = sum[SUM_W-1:PRE_SHIFT];
    assign qm     = QM_W'(x_next[X_W-1:LO_BITS]) * QM_W'(RECIP);
    assign q_next = qm[QM_W-1:RECIP_SHIFT];

    // remainder stays below three divisors
    assign rq  = RQ_W'(q_reg) * RQ_W'(DIVISOR);
    assign rem = x_reg - rq[X_W-1:0];

    // final correction
    always_comb
    begin
        if (r_reg >= DIV_TWO)
        begin
            step_next = q2_reg + Q_W'(2);
        end
        else if (r_reg >= DIV_ONE)
        begin
            step_next = q2_reg + Q_W'(1);
        end
        else
        begin
            step_next = q2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pstep_reg <= PROD_W'(speed_mag) * PROD_W'(tick);
            x_reg     <= x_next;
            q_reg     <= q_next;
            r_reg     <= rem[R_W-1:0];
            q2_reg    <= q_reg;
            step_reg  <= step_next[STEP_W-1:0];
        end
    end

    assign step = step_reg;

endmodule

// ----- design/motor_move_mode_controller.sv -----
`timescale 1ns / 1ps
// Motor move-mode controller: one control tick per input transaction.
// Input channel (in_valid/in_ready) carries tick_us, power_tenths and the
// degrees, rotations and seconds goals. Output channel (out_valid/out_ready)
// returns exactly one result per tick: shaft_angle, shaft_speed, effort_echo,
// move_done and active_mode, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 max_speed,
// 1 invert_direction) at once; write only while no tick is in flight.
// Path: each tick passes stages 0 to 5, and its result is then registered.
// Throughput: one tick per cycle outside receiver stalls. The integration
// step of a tick uses the speed magnitude of the tick before it, ready after
// that tick's second stage, so the six-stage pipeline never waits on itself.
// Receiver stall: the whole pipeline and the controller state freeze while
// a result waits; in_ready is low then and drops no transaction.
// Reset: angles, run time, goals, velocity and done flag clear to zero,
// max_speed returns to 990000 and invert_direction to 0.
`include "motor_move_mode_controller_assert.svh"

module motor_move_mode_controller import mmmc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [MAXSPD_W-1:0]        cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TICK_W-1:0]          tick_us,
    input  logic signed [POWER_W-1:0]  power_tenths,
    input  logic signed [DEG_W-1:0]    degrees_goal,
    input  logic signed [ROT_W-1:0]    rotations_goal,
    input  logic [SECS_W-1:0]          seconds_goal,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [ANGLE_OUT_W-1:0] shaft_angle,
    output logic signed [SPEED_W-1:0] shaft_speed,
    output logic signed [POWER_W-1:0] effort_echo,
    output logic                       move_done,
    output logic [MODE_W-1:0]          active_mode
);

    localparam int NUM_STAGES = 6;
    localparam int CMAG_W     = 10;
    localparam int PROD1_W    = CMAG_W + MAXSPD_W;
    localparam int MAG_RCP_W  = 30;
    localparam int MAG_PROD_W = (PROD1_W - 3) + MAG_RCP_W;
    localparam int MAG_SHIFT  = 36;
    localparam int CMP_W      = ANGLE_BITS + 1;

    localparam logic signed [POWER_W-1:0] POWER_LIMIT  = 12'sd1000;
    localparam logic [CMAG_W-1:0]         DEAD_BAND    = 10'd5;
    localparam logic [GOAL_W-1:0]         DEG_DEADZONE = 32'd500;
    // ceil(2^36 / 125): exact floor divide by 125 for 29-bit values
    localparam logic [MAG_RCP_W-1:0]      MAG_RECIP    = 30'd549755814;
    localparam logic signed [GOAL_W-1:0]  DEG_PER_REV  = 32'sd360;

    // configuration
    logic [MAXSPD_W-1:0] max_speed_reg;
    logic                invert_reg;

    // pipeline control and payload
    logic                    adv;
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [TICK_W-1:0]       tick0_reg;
    logic signed [POWER_W-1:0] power0_reg;
    logic signed [DEG_W-1:0] deg0_reg;
    logic signed [ROT_W-1:0] rot0_reg;
    logic [SECS_W-1:0]       secs0_reg;
    mmmc_item_t              stage_reg [1:NUM_STAGES-1];
    logic [PROD1_W-1:0]      prod1_reg;
    logic [MAXSPD_W-1:0]     mag_last_reg;

    // controller state
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic [ANGLE_BITS-1:0]     abs_reg;
    logic [ANGLE_BITS-1:0]     rel_reg, rel_next;
    logic [SECS_W-1:0]         run_reg, run_next;
    logic signed [GOAL_W-1:0]  goal_reg, goal_next;
    logic                      met_reg, met_next;
    logic signed [DEG_W-1:0]   last_deg_reg, last_deg_next;
    logic signed [ROT_W-1:0]   last_rot_reg, last_rot_next;
    logic [SECS_W-1:0]         last_secs_reg, last_secs_next;
    logic [MODE_W-1:0]         mode_next;

    // result register
    logic                        out_valid_reg;
    logic signed [ANGLE_OUT_W-1:0] out_angle_reg;
    logic signed [SPEED_W-1:0]   out_speed_reg;
    logic signed [POWER_W-1:0]   out_power_reg;
    logic                        out_done_reg;
    logic [MODE_W-1:0]           out_mode_reg;

    // stage 0 logic
    logic signed [POWER_W-1:0] p_clamp;
    logic signed [POWER_W-1:0] p_abs;
    logic [CMAG_W-1:0]         cmag;
    logic [PROD1_W-1:0]        prod1_c;
    logic signed [GOAL_W-1:0]  deg0_ext;
    logic [GOAL_W-1:0]         deg0_mag;
    mmmc_item_t                item0;

    // stage 1 logic
    logic [MAG_PROD_W-1:0] mag_prod;
    logic [MAXSPD_W-1:0]   mag_c;

    // decision stage logic
    mmmc_item_t                s;
    logic [STEP_W-1:0]         step_w;
    logic [ANGLE_BITS-1:0]     step_ext;
    logic                      spd_nz;
    logic [ANGLE_BITS-1:0]     abs_int;
    logic [ANGLE_BITS-1:0]     rel_int;
    logic [SECS_W:0]           run_sum;
    logic [SECS_W-1:0]         run_int;
    logic signed [GOAL_W-1:0]  deg_ext;
    logic signed [GOAL_W-1:0]  deg_diff;
    logic [GOAL_W-1:0]         deg_dmag;
    logic                      move_act;
    logic                      restart_deg;
    logic                      restart_rot;
    logic                      restart_tm;
    logic signed [GOAL_W-1:0]  goal_mv;
    logic [ANGLE_BITS-1:0]     rel_mv;
    logic [GOAL_W-1:0]         goal_mag;
    logic signed [CMP_W-1:0]   rel_s;
    logic signed [CMP_W-1:0]   gpos;
    logic signed [CMP_W-1:0]   gneg;
    logic                      in_goal;
    logic [SECS_W-1:0]         run_tm;
    logic                      in_time;
    logic signed [SPEED_W-1:0] mag_spd;
    logic signed [SPEED_W-1:0] base_spd;
    logic [ANGLE_OUT_W-1:0]    ang_out;

    // assertion helpers
    logic [SPEED_W-1:0] out_spd_mag;
    logic [SPEED_W-1:0] spd_limit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            invert_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                CFG_INVERT:    invert_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // pipeline moves as a whole unless a result is stuck
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 0: clamp, dead band, power times full speed
    assign p_clamp  = (power0_reg > POWER_LIMIT)  ? POWER_LIMIT :
                      (power0_reg < -POWER_LIMIT) ? -POWER_LIMIT : power0_reg;
    assign p_abs    = p_clamp[POWER_W-1] ? -p_clamp : p_clamp;
    assign cmag     = p_abs[CMAG_W-1:0];
    assign prod1_c  = PROD1_W'(cmag) * PROD1_W'(max_speed_reg);
    assign deg0_ext = GOAL_W'(deg0_reg);
    assign deg0_mag = deg0_ext[GOAL_W-1] ? GOAL_W'(-deg0_ext) : GOAL_W'(deg0_ext);

    always_comb
    begin
        item0         = '0;
        item0.tick    = tick0_reg;
        item0.power   = power0_reg;
        item0.deg     = deg0_reg;
        item0.deg_act = deg0_mag > DEG_DEADZONE;
        item0.rot     = rot0_reg;
        item0.rot360  = GOAL_W'(rot0_reg) * DEG_PER_REV;
        item0.secs    = secs0_reg;
        item0.pzero   = cmag < DEAD_BAND;
        item0.cneg    = p_clamp[POWER_W-1];
    end

    // stage 1: divide by 1000 (shift by 3, reciprocal of 125)
    assign mag_prod = MAG_PROD_W'(prod1_reg[PROD1_W-1:3]) * MAG_PROD_W'(MAG_RECIP);
    assign mag_c    = mag_prod[MAG_SHIFT +: MAXSPD_W];

    // control registers of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            mag_last_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], in_valid};
            if (vld_reg[1])
            begin
                mag_last_reg <= mag_c;
            end
        end
    end

    // payload registers of the pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_valid)
            begin
                tick0_reg  <= tick_us;
                power0_reg <= power_tenths;
                deg0_reg   <= degrees_goal;
                rot0_reg   <= rotations_goal;
                secs0_reg  <= seconds_goal;
            end
            stage_reg[1] <= item0;
            prod1_reg    <= prod1_c;
            stage_reg[2] <= stage_reg[1];
            stage_reg[2].mag <= mag_c;
            for (int i = 3; i < NUM_STAGES; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    // stages 2 to 5: rounded step from the previous tick's speed magnitude
    mmmc_step_calc u_step
    (
        .clk       (clk),
        .en        (adv),
        .speed_mag (mag_last_reg),
        .tick      (stage_reg[1].tick),
        .step      (step_w)
    );

    // decision stage: integrate with the previous velocity
    assign s        = stage_reg[NUM_STAGES-1];
    assign step_ext = ANGLE_BITS'(step_w);
    assign spd_nz   = speed_reg != '0;
    assign abs_int  = !spd_nz ? abs_reg :
                      (speed_reg[SPEED_W-1] ? abs_reg - step_ext : abs_reg + step_ext);
    assign rel_int  = !spd_nz ? rel_reg :
                      (speed_reg[SPEED_W-1] ? rel_reg - step_ext : rel_reg + step_ext);
    assign run_sum  = (SECS_W+1)'(run_reg) + (SECS_W+1)'(s.tick);
    assign run_int  = !spd_nz ? run_reg : (run_sum[SECS_W] ? '1 : run_sum[SECS_W-1:0]);

    // target changes
    assign deg_ext     = GOAL_W'($signed(s.deg));
    assign deg_diff    = deg_ext - GOAL_W'($signed(last_deg_reg));
    assign deg_dmag    = deg_diff[GOAL_W-1] ? GOAL_W'(-deg_diff) : GOAL_W'(deg_diff);
    assign move_act    = s.deg_act || (s.rot != '0);
    assign restart_deg = s.deg_act && (deg_dmag > DEG_DEADZONE);
    assign restart_rot = !s.deg_act && (s.rot != '0) && (s.rot != last_rot_reg);
    assign restart_tm  = s.secs != last_seconds_hold();

    function automatic logic [SECS_W-1:0] last_seconds_hold();
        return last_secs_reg;
    endfunction

    // distance check: |rel| < |goal| as -goal < rel < goal
    assign goal_mv  = restart_deg ? deg_ext : (restart_rot ? s.rot360 : goal_reg);
    assign rel_mv   = (restart_deg || restart_rot) ? '0 : rel_int;
    assign goal_mag = goal_mv[GOAL_W-1] ? GOAL_W'(-goal_mv) : GOAL_W'(goal_mv);
    assign rel_s    = $signed({rel_mv[ANGLE_BITS-1], rel_mv});
    assign gpos     = $signed(CMP_W'(goal_mag));
    assign gneg     = -gpos;
    assign in_goal  = (rel_s < gpos) && (rel_s > gneg);

    // timed check
    assign run_tm  = restart_tm ? '0 : run_int;
    assign in_time = run_tm < s.secs;

    // velocity candidates
    assign mag_spd  = $signed(SPEED_W'(s.mag));
    assign base_spd = (s.cneg ^ invert_reg) ? -mag_spd : mag_spd;

    // mode priority and next state
    always_comb
    begin
        rel_next       = rel_int;
        run_next       = run_int;
        met_next       = met_reg;
        goal_next      = goal_reg;
        last_deg_next  = last_deg_reg;
        last_rot_next  = last_rot_reg;
        last_secs_next = last_secs_reg;
        speed_next     = '0;
        mode_next      = MODE_OFF;
        if (move_act)
        begin
            mode_next = s.deg_act ? MODE_DEG : MODE_ROT;
            if (restart_deg)
            begin
                last_deg_next = s.deg;
            end
            if (restart_rot)
            begin
                last_rot_next = s.rot;
            end
            if (restart_deg || restart_rot)
            begin
                rel_next  = '0;
                met_next  = 1'b0;
                goal_next = goal_mv;
            end
            if (s.pzero)
            begin
                met_next = 1'b1;
            end
            else if (!met_next)
            begin
                if (in_goal)
                begin
                    speed_next = goal_mv[GOAL_W-1] ? -mag_spd : mag_spd;
                end
                else
                begin
                    met_next = 1'b1;
                end
            end
        end
        else if (s.secs != '0)
        begin
            mode_next = MODE_TIMED;
            if (restart_tm)
            begin
                run_next       = '0;
                met_next       = 1'b0;
                last_secs_next = s.secs;
            end
            if (s.pzero)
            begin
                met_next = 1'b1;
            end
            else if (!met_next)
            begin
                if (in_time)
                begin
                    speed_next = base_spd;
                end
                else
                begin
                    met_next = 1'b1;
                end
            end
        end
        else if (!s.pzero)
        begin
            mode_next  = MODE_FREE;
            speed_next = base_spd;
            met_next   = 1'b0;
        end
    end

    // absolute angle onto the output width
    generate
        if (ANGLE_BITS >= ANGLE_OUT_W)
        begin : g_ang_trunc
            assign ang_out = abs_int[ANGLE_OUT_W-1:0];
        end
        else
        begin : g_ang_sext
            assign ang_out = {{(ANGLE_OUT_W-ANGLE_BITS){abs_int[ANGLE_BITS-1]}}, abs_int};
        end
    endgenerate

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= '0;
            abs_reg       <= '0;
            rel_reg       <= '0;
            run_reg       <= '0;
            goal_reg      <= '0;
            met_reg       <= 1'b0;
            last_deg_reg  <= '0;
            last_rot_reg  <= '0;
            last_secs_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[NUM_STAGES-1];
            if (vld_reg[NUM_STAGES-1])
            begin
                speed_reg     <= speed_next;
                abs_reg       <= abs_int;
                rel_reg       <= rel_next;
                run_reg       <= run_next;
                goal_reg      <= goal_next;
                met_reg       <= met_next;
                last_deg_reg  <= last_deg_next;
                last_rot_reg  <= last_rot_next;
                last_secs_reg <= last_secs_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[NUM_STAGES-1])
        begin
            out_angle_reg <= $signed(ang_out);
            out_speed_reg <= speed_next;
            out_power_reg <= s.power;
            out_done_reg  <= met_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign shaft_angle = out_angle_reg;
    assign shaft_speed = out_speed_reg;
    assign effort_echo = out_power_reg;
    assign move_done   = out_done_reg;
    assign active_mode = out_mode_reg;

    // checks
    assign out_spd_mag = out_speed_reg[SPEED_W-1] ? SPEED_W'(-out_speed_reg)
                                                  : SPEED_W'(out_speed_reg);
    assign spd_limit   = SPEED_W'(max_speed_reg);

    `MMMC_ASSERT_IMP(a_off_no_speed, clk, rst_n, out_valid_reg && (out_mode_reg == MODE_OFF), out_speed_reg == '0, "speed nonzero in off mode")
    `MMMC_ASSERT_IMP(a_speed_bound, clk, rst_n, out_valid_reg, out_spd_mag <= spd_limit, "speed above max_speed")
    `MMMC_ASSERT_IMP(a_done_still, clk, rst_n, out_valid_reg && out_done_reg && (out_mode_reg == MODE_DEG || out_mode_reg == MODE_ROT || out_mode_reg == MODE_TIMED), out_speed_reg == '0, "finished move still driving")
    `MMMC_ASSERT_NXT(a_stall_freeze, clk, rst_n, out_valid_reg && !out_ready, $stable(speed_reg) && $stable(abs_reg) && $stable(met_reg), "state moved during output stall")

endmodule
